// ===== rtl/core/mwm_pkg.sv =====
package mwm_pkg;

	// Field widths
	localparam int AXIS_W     = 16;
	localparam int SUM_W      = 17;
	localparam int MAG_W      = 17;
	localparam int RPM_W      = 10;
	localparam int DZ_W       = 15;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SPD_W      = 16;
	localparam int LANES      = 4;

	// Tank / arcade (and zero-translation x-arcade) path: N = axis * rpm, divided by 2048
	localparam int SIMPLE_W     = 28;
	localparam int SIMPLE_SHIFT = 11;

	// X-arcade path
	localparam int SQ_W    = 32;
	localparam int ROOT_W  = 24;
	localparam int RAD_W   = 48;
	localparam int REM_W   = 26;
	localparam int TM_W    = 34;
	localparam int PROD_W  = 42;
	localparam int NUM_W   = 43;
	localparam int NRPM_W  = 54;
	localparam int DIV_LOW = 19;
	localparam int Y_W     = NRPM_W - DIV_LOW;
	localparam int Q_W     = 16;

	localparam logic [RPM_W-1:0] RPM_RESET = 10'd200;

	typedef enum logic [MODE_W-1:0] {
		MODE_TANK   = 2'd0,
		MODE_ARCADE = 2'd1,
		MODE_XARC   = 2'd2
	} drive_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRIVE_MODE = 2'd0,
		REG_DEADZONE   = 2'd1,
		REG_FULL_RPM   = 2'd2
	} cfg_reg_t;

	// Sideband carried through the square-root stages
	typedef struct packed {
		logic                          simple;
		logic [LANES-1:0][SPD_W-1:0]   spd;
		logic signed [SUM_W-1:0]       cp;
		logic signed [SUM_W-1:0]       cm;
		logic signed [TM_W-1:0]        tm;
		logic [MAG_W-1:0]              m;
	} carry_t;

	// Sideband carried through the back half
	typedef struct packed {
		logic                          simple;
		logic [LANES-1:0][SPD_W-1:0]   spd;
		logic [MAG_W-1:0]              m;
	} tail_t;

	function automatic logic [MAG_W-1:0] abs17(logic signed [AXIS_W-1:0] x);
		return x[AXIS_W-1] ? (MAG_W'(0) - {1'b1, x}) : {1'b0, x};
	endfunction

	function automatic logic signed [AXIS_W-1:0] dz_apply(logic signed [AXIS_W-1:0] x,
			logic [DZ_W-1:0] dz);
		logic [MAG_W-1:0] mag;
		mag = abs17(x);
		return (mag < MAG_W'(dz)) ? '0 : x;
	endfunction

	// Apply sign to a magnitude and clamp to 16 bits signed
	function automatic logic [SPD_W-1:0] sat16(logic neg, logic [SPD_W:0] q);
		logic [SPD_W:0] nq;
		nq = (SPD_W+1)'(0) - q;
		if (!neg)
			return (q > (SPD_W+1)'(32767)) ? 16'h7FFF : q[SPD_W-1:0];
		else
			return (q > (SPD_W+1)'(32768)) ? 16'h8000 : nq[SPD_W-1:0];
	endfunction

	// Round N / 2048 to nearest, ties away from zero, then clamp
	function automatic logic [SPD_W-1:0] round_simple(logic signed [SIMPLE_W-1:0] n);
		logic [SIMPLE_W-1:0] mag;
		logic [SIMPLE_W-1:0] q;
		mag = n[SIMPLE_W-1] ? (SIMPLE_W'(0) - n) : n;
		q = (mag + SIMPLE_W'(1 << (SIMPLE_SHIFT-1))) >> SIMPLE_SHIFT;
		return sat16(n[SIMPLE_W-1], q[SPD_W:0]);
	endfunction

endpackage

// ===== rtl/core/mecanum_wheel_mixer.sv =====
// Mecanum wheel mixer: one beat of joystick axes in, one beat of four wheel
// speeds out (rpm, Q11.4, saturated).
// Input channel: in_valid / in_stall with first_axis, second_axis, turn_axis
// (Q1.15). Output channel: out_valid / out_stall with the four wheel speeds.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// drive_mode (0), deadzone (1) or full-scale rpm (2); other indexes are dropped.
// Write config only while the pipe is empty.
// The pipe holds three front stages, a 24-stage square-root pipe (one root
// bit per stage), four product/sum stages, a 16-stage divider (one quotient
// bit per stage) and the output register. Throughput is one beat per cycle
// in every mode while the output beat is not stalled.
// The whole pipe advances together; when the output register holds a beat
// that the receiver stalls, every stage holds and in_stall rises in the same
// cycle, so nothing is dropped or repeated.
// Reset clears all valid bits and loads drive_mode=tank, deadzone=0,
// full-scale rpm=200.
module mecanum_wheel_mixer (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [mwm_pkg::AXIS_W-1:0]       first_axis,
	input  logic signed [mwm_pkg::AXIS_W-1:0]       second_axis,
	input  logic signed [mwm_pkg::AXIS_W-1:0]       turn_axis,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [mwm_pkg::SPD_W-1:0]        front_left_speed,
	output logic signed [mwm_pkg::SPD_W-1:0]        front_right_speed,
	output logic signed [mwm_pkg::SPD_W-1:0]        rear_left_speed,
	output logic signed [mwm_pkg::SPD_W-1:0]        rear_right_speed,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [mwm_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [mwm_pkg::CFG_DATA_W-1:0]          cfg_data
);

	localparam int LANES  = mwm_pkg::LANES;
	localparam int ROOT_W = mwm_pkg::ROOT_W;
	localparam int Q_W    = mwm_pkg::Q_W;
	localparam int Y_W    = mwm_pkg::Y_W;

	logic en;

	// Config registers
	logic [mwm_pkg::MODE_W-1:0] mode_q;
	logic [mwm_pkg::DZ_W-1:0]   dz_q;
	logic [mwm_pkg::RPM_W-1:0]  rpm_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mwm_pkg::MODE_TANK;
			dz_q   <= '0;
			rpm_q  <= mwm_pkg::RPM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mwm_pkg::REG_DRIVE_MODE: mode_q <= cfg_data[mwm_pkg::MODE_W-1:0];
				mwm_pkg::REG_DEADZONE:   dz_q   <= cfg_data[mwm_pkg::DZ_W-1:0];
				mwm_pkg::REG_FULL_RPM:   rpm_q  <= cfg_data[mwm_pkg::RPM_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the whole pipe unless the output beat is stalled
	logic out_valid_q;
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// ---------------- s1: capture, apply deadzone ----------------
	logic                                v_s1;
	logic signed [mwm_pkg::AXIS_W-1:0]   f_s1, s_s1, t_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1 <= mwm_pkg::dz_apply(first_axis, dz_q);
			s_s1 <= mwm_pkg::dz_apply(second_axis, dz_q);
			t_s1 <= mwm_pkg::dz_apply(turn_axis, dz_q);
		end
	end

	// ---------------- s2: squares, sums, mode select ----------------
	logic signed [mwm_pkg::SUM_W-1:0] sn_c [LANES];
	logic                             simple_c;
	logic [mwm_pkg::MAG_W-1:0]        m_c;
	logic signed [mwm_pkg::SUM_W-1:0] fx, sx, tx;

	always_comb begin
		fx  = mwm_pkg::SUM_W'(f_s1);
		sx  = mwm_pkg::SUM_W'(s_s1);
		tx  = mwm_pkg::SUM_W'(t_s1);
		m_c = mwm_pkg::abs17(f_s1) + mwm_pkg::abs17(s_s1);
		simple_c = 1'b1;
		for (int i = 0; i < LANES; i++)
			sn_c[i] = '0;
		unique case (mode_q)
			mwm_pkg::MODE_TANK: begin
				sn_c[0] = fx;
				sn_c[1] = sx;
				sn_c[2] = fx;
				sn_c[3] = sx;
			end
			mwm_pkg::MODE_ARCADE: begin
				sn_c[0] = fx + tx;
				sn_c[1] = fx - tx;
				sn_c[2] = fx + tx;
				sn_c[3] = fx - tx;
			end
			mwm_pkg::MODE_XARC: begin
				// no translation: turn term alone over the plain 2048 divisor
				simple_c = (m_c == '0);
				sn_c[0] = tx;
				sn_c[1] = -tx;
				sn_c[2] = tx;
				sn_c[3] = -tx;
			end
			default: ;
		endcase
	end

	logic                                v_s2;
	logic signed [mwm_pkg::SUM_W-1:0]    sn_s2 [LANES];
	logic                                simple_s2;
	logic signed [mwm_pkg::SQ_W-1:0]     ff_s2, ss_s2;
	logic signed [mwm_pkg::SUM_W-1:0]    cp_s2, cm_s2;
	logic [mwm_pkg::MAG_W-1:0]           m_s2;
	logic signed [mwm_pkg::AXIS_W-1:0]   t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s2     <= sn_c;
			simple_s2 <= simple_c;
			ff_s2     <= f_s1 * f_s1;
			ss_s2     <= s_s1 * s_s1;
			cp_s2     <= fx + sx;
			cm_s2     <= fx - sx;
			m_s2      <= m_c;
			t_s2      <= t_s1;
		end
	end

	// ---------------- s3: radicand, rpm and turn products ----------------
	logic                                  v_s3;
	logic signed [mwm_pkg::SIMPLE_W-1:0]   np_s3 [LANES];
	logic                                  simple_s3;
	logic [mwm_pkg::RAD_W-1:0]             rad_s3;
	logic signed [mwm_pkg::SUM_W-1:0]      cp_s3, cm_s3;
	logic [mwm_pkg::MAG_W-1:0]             m_s3;
	logic signed [mwm_pkg::TM_W-1:0]       tm_s3;
	logic [mwm_pkg::SQ_W-1:0]              sq_c;

	assign sq_c = $unsigned(ff_s2) + $unsigned(ss_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++)
				np_s3[i] <= sn_s2[i] * $signed({1'b0, rpm_q});
			simple_s3 <= simple_s2;
			rad_s3    <= {sq_c, 16'd0};
			cp_s3     <= cp_s2;
			cm_s3     <= cm_s2;
			m_s3      <= m_s2;
			tm_s3     <= t_s2 * $signed({1'b0, m_s2});
		end
	end

	// ---------------- s4: square root, one root bit per stage ----------------
	mwm_pkg::carry_t cy0_c;

	always_comb begin
		cy0_c.simple = simple_s3;
		for (int i = 0; i < LANES; i++)
			cy0_c.spd[i] = mwm_pkg::round_simple(np_s3[i]);
		cy0_c.cp = cp_s3;
		cy0_c.cm = cm_s3;
		cy0_c.tm = tm_s3;
		cy0_c.m  = m_s3;
	end

	logic                              rt_v_s4    [ROOT_W];
	logic [mwm_pkg::REM_W-1:0]         rt_rem_s4  [ROOT_W];
	logic [ROOT_W-1:0]                 rt_root_s4 [ROOT_W];
	logic [mwm_pkg::RAD_W-1:0]         rt_rad_s4  [ROOT_W];
	mwm_pkg::carry_t                   rt_cy_s4   [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		logic                          vin;
		logic [mwm_pkg::REM_W-1:0]     rem_in, rem2, trial;
		logic [ROOT_W-1:0]             root_in;
		logic [mwm_pkg::RAD_W-1:0]     rad_in;
		mwm_pkg::carry_t               cy_in;

		if (k == 0) begin : g_first
			assign vin     = v_s3;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad_s3;
			assign cy_in   = cy0_c;
		end else begin : g_next
			assign vin     = rt_v_s4[k-1];
			assign rem_in  = rt_rem_s4[k-1];
			assign root_in = rt_root_s4[k-1];
			assign rad_in  = rt_rad_s4[k-1];
			assign cy_in   = rt_cy_s4[k-1];
		end

		assign rem2  = {rem_in[mwm_pkg::REM_W-3:0], rad_in[mwm_pkg::RAD_W-1 -: 2]};
		assign trial = {root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				rt_v_s4[k] <= 1'b0;
			else if (en)
				rt_v_s4[k] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem2 >= trial) begin
					rt_rem_s4[k]  <= rem2 - trial;
					rt_root_s4[k] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rt_rem_s4[k]  <= rem2;
					rt_root_s4[k] <= {root_in[ROOT_W-2:0], 1'b0};
				end
				rt_rad_s4[k] <= {rad_in[mwm_pkg::RAD_W-3:0], 2'b00};
				rt_cy_s4[k]  <= cy_in;
			end
		end
	end

	// ---------------- s5: hypot times (f+s), (f-s) ----------------
	mwm_pkg::carry_t                    cy_last;
	logic [ROOT_W-1:0]                  h_c;
	logic                               v_s5;
	logic signed [mwm_pkg::PROD_W-1:0]  pp_s5, pm_s5, tm8_s5;
	mwm_pkg::tail_t                     tail_s5;

	assign cy_last = rt_cy_s4[ROOT_W-1];
	assign h_c     = rt_root_s4[ROOT_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= rt_v_s4[ROOT_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s5  <= $signed({1'b0, h_c}) * cy_last.cp;
			pm_s5  <= $signed({1'b0, h_c}) * cy_last.cm;
			tm8_s5 <= {cy_last.tm, 8'd0};
			tail_s5.simple <= cy_last.simple;
			tail_s5.spd    <= cy_last.spd;
			tail_s5.m      <= cy_last.m;
		end
	end

	// ---------------- s6: add turn term per wheel ----------------
	logic                               v_s6;
	logic signed [mwm_pkg::NUM_W-1:0]   n_s6 [LANES];
	mwm_pkg::tail_t                     tail_s6;
	logic signed [mwm_pkg::NUM_W-1:0]   ppx, pmx, tmx;

	assign ppx = mwm_pkg::NUM_W'(pp_s5);
	assign pmx = mwm_pkg::NUM_W'(pm_s5);
	assign tmx = mwm_pkg::NUM_W'(tm8_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s6[0] <= ppx + tmx;
			n_s6[1] <= pmx - tmx;
			n_s6[2] <= pmx + tmx;
			n_s6[3] <= ppx - tmx;
			tail_s6 <= tail_s5;
		end
	end

	// ---------------- s7: scale by motor rpm ----------------
	logic                               v_s7;
	logic signed [mwm_pkg::NRPM_W-1:0]  nr_s7 [LANES];
	mwm_pkg::tail_t                     tail_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++)
				nr_s7[i] <= n_s6[i] * $signed({1'b0, rpm_q});
			tail_s7 <= tail_s6;
		end
	end

	// ---------------- s8: magnitude, rounding offset, overflow check ----------------
	logic [mwm_pkg::NRPM_W-1:0]  mag_c [LANES];
	logic [mwm_pkg::NRPM_W-1:0]  x_c   [LANES];
	logic [LANES-1:0][Y_W-1:0]   y_c;
	logic [LANES-1:0]            sat_c;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mag_c[i] = nr_s7[i][mwm_pkg::NRPM_W-1] ?
				(mwm_pkg::NRPM_W'(0) - nr_s7[i]) : nr_s7[i];
			// add half the divisor (m * 2^18), then drop the 2^19 factor
			x_c[i]   = mag_c[i] + (mwm_pkg::NRPM_W'(tail_s7.m) << (mwm_pkg::DIV_LOW - 1));
			y_c[i]   = x_c[i][mwm_pkg::NRPM_W-1:mwm_pkg::DIV_LOW];
			sat_c[i] = y_c[i] >= (Y_W'(tail_s7.m) << Q_W);
		end
	end

	logic                        v_s8;
	logic [LANES-1:0][Y_W-1:0]   y_s8;
	logic [LANES-1:0]            neg_s8, sat_s8;
	mwm_pkg::tail_t              tail_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s8 <= y_c;
			for (int i = 0; i < LANES; i++)
				neg_s8[i] <= nr_s7[i][mwm_pkg::NRPM_W-1];
			sat_s8  <= sat_c;
			tail_s8 <= tail_s7;
		end
	end

	// ---------------- s9: restoring divide by m, one quotient bit per stage ----------------
	logic                        dv_v_s9    [Q_W];
	logic [LANES-1:0][Y_W-1:0]   dv_y_s9    [Q_W];
	logic [LANES-1:0][Q_W-1:0]   dv_q_s9    [Q_W];
	logic [LANES-1:0]            dv_neg_s9  [Q_W];
	logic [LANES-1:0]            dv_sat_s9  [Q_W];
	mwm_pkg::tail_t              dv_tail_s9 [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		localparam int B = Q_W - 1 - j;
		logic                        vin;
		logic [LANES-1:0][Y_W-1:0]   y_in;
		logic [LANES-1:0][Q_W-1:0]   q_in;
		logic [LANES-1:0]            neg_in, sat_in;
		mwm_pkg::tail_t              tail_in;
		logic [Y_W-1:0]              dv;

		if (j == 0) begin : g_first
			assign vin     = v_s8;
			assign y_in    = y_s8;
			assign q_in    = '0;
			assign neg_in  = neg_s8;
			assign sat_in  = sat_s8;
			assign tail_in = tail_s8;
		end else begin : g_next
			assign vin     = dv_v_s9[j-1];
			assign y_in    = dv_y_s9[j-1];
			assign q_in    = dv_q_s9[j-1];
			assign neg_in  = dv_neg_s9[j-1];
			assign sat_in  = dv_sat_s9[j-1];
			assign tail_in = dv_tail_s9[j-1];
		end

		assign dv = Y_W'(tail_in.m) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s9[j] <= 1'b0;
			else if (en)
				dv_v_s9[j] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < LANES; i++) begin
					if (y_in[i] >= dv) begin
						dv_y_s9[j][i] <= y_in[i] - dv;
						dv_q_s9[j][i] <= q_in[i] | (Q_W'(1) << B);
					end else begin
						dv_y_s9[j][i] <= y_in[i];
						dv_q_s9[j][i] <= q_in[i];
					end
				end
				dv_neg_s9[j]  <= neg_in;
				dv_sat_s9[j]  <= sat_in;
				dv_tail_s9[j] <= tail_in;
			end
		end
	end

	// ---------------- output register: pick path, sign and clamp ----------------
	logic [LANES-1:0][mwm_pkg::SPD_W-1:0] res_c;
	logic [LANES-1:0][mwm_pkg::SPD_W-1:0] spd_q;
	mwm_pkg::tail_t                       tail_l;

	assign tail_l = dv_tail_s9[Q_W-1];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (tail_l.simple)
				res_c[i] = tail_l.spd[i];
			else if (dv_sat_s9[Q_W-1][i])
				res_c[i] = mwm_pkg::sat16(dv_neg_s9[Q_W-1][i], '1);
			else
				res_c[i] = mwm_pkg::sat16(dv_neg_s9[Q_W-1][i],
					{1'b0, dv_q_s9[Q_W-1][i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= dv_v_s9[Q_W-1];
	end

	always_ff @(posedge clk) begin
		if (en)
			spd_q <= res_c;
	end

	assign out_valid         = out_valid_q;
	assign front_left_speed  = spd_q[0];
	assign front_right_speed = spd_q[1];
	assign rear_left_speed   = spd_q[2];
	assign rear_right_speed  = spd_q[3];

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Mode value 3 is not a legal drive mode: the block must zero every wheel.
	localparam logic [mwm_pkg::MODE_W-1:0]    MODE_UNUSED  = 2'd3;
	// Index 3 selects no register: the write must be dropped.
	localparam logic [mwm_pkg::CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
	localparam int                            STALL_LIMIT  = 4000;
	localparam int                            TAIL_CYCLES  = 60;
	localparam int                            SEGMENTS     = 12;
	localparam int                            SEG_ITEMS    = 34;
	localparam int                            DIR_ROWS     = 17;

	// Wheel order: front left, front right, rear left, rear right
	typedef logic [mwm_pkg::LANES-1:0][mwm_pkg::SPD_W-1:0] wheel_set_t;

	typedef struct {
		logic [mwm_pkg::CFG_DATA_W-1:0]   mode_w;
		logic [mwm_pkg::CFG_DATA_W-1:0]   dz_w;
		logic [mwm_pkg::CFG_DATA_W-1:0]   rpm_w;
		logic signed [mwm_pkg::AXIS_W-1:0] a1;
		logic signed [mwm_pkg::AXIS_W-1:0] a2;
		logic signed [mwm_pkg::AXIS_W-1:0] at;
		bit                               typed;
		wheel_set_t                       want;
	} dir_row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic signed [mwm_pkg::AXIS_W-1:0]  first_axis;
	logic signed [mwm_pkg::AXIS_W-1:0]  second_axis;
	logic signed [mwm_pkg::AXIS_W-1:0]  turn_axis;
	logic                               out_valid;
	logic                               out_stall;
	logic signed [mwm_pkg::SPD_W-1:0]   front_left_speed;
	logic signed [mwm_pkg::SPD_W-1:0]   front_right_speed;
	logic signed [mwm_pkg::SPD_W-1:0]   rear_left_speed;
	logic signed [mwm_pkg::SPD_W-1:0]   rear_right_speed;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [mwm_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [mwm_pkg::CFG_DATA_W-1:0]     cfg_data;

	// Shadow copy of the block's registers, updated on each accepted config beat
	logic [mwm_pkg::MODE_W-1:0]         cur_mode;
	logic [mwm_pkg::DZ_W-1:0]           cur_dz;
	logic [mwm_pkg::RPM_W-1:0]          cur_rpm;

	wheel_set_t                speeds_due [$];
	int                        errors;
	int                        beats_in;
	int                        beats_out;
	int                        mode_beats [4];
	int                        idle_cycles;
	int                        send_idle_pct;
	int                        recv_stall_pct;
	string                     wheel_name [mwm_pkg::LANES];
	dir_row_t                  dir_rows [DIR_ROWS];

	mecanum_wheel_mixer i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.first_axis        (first_axis),
		.second_axis       (second_axis),
		.turn_axis         (turn_axis),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.front_left_speed  (front_left_speed),
		.front_right_speed (front_right_speed),
		.rear_left_speed   (rear_left_speed),
		.rear_right_speed  (rear_right_speed),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Wheel speed predictor
	// ---------------------------------------------------------------------

	// Axis magnitude strictly below the deadzone reads as zero
	function automatic longint dead_axis(logic signed [mwm_pkg::AXIS_W-1:0] x);
		longint v;
		longint mag;
		v = longint'(x);
		mag = (v < 0) ? -v : v;
		return (mag < longint'(cur_dz)) ? 0 : v;
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// n / d rounded to nearest with ties away from zero, clamped to 16 bits
	function automatic logic [mwm_pkg::SPD_W-1:0] round_clamp(longint n, longint d);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = (mag + d / 2) / d;
		if (n < 0)
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[mwm_pkg::SPD_W-1:0];
	endfunction

	function automatic wheel_set_t mix_wheels(logic signed [mwm_pkg::AXIS_W-1:0] a1,
			logic signed [mwm_pkg::AXIS_W-1:0] a2, logic signed [mwm_pkg::AXIS_W-1:0] at);
		longint     f;
		longint     s;
		longint     t;
		longint     rpm;
		longint     m;
		longint     h;
		longint     tt;
		longint     pa;
		longint     pb;
		longint     d;
		longint     n [mwm_pkg::LANES];
		wheel_set_t r;
		f = dead_axis(a1);
		s = dead_axis(a2);
		t = dead_axis(at);
		rpm = longint'(cur_rpm);
		d = 2048;
		for (int k = 0; k < mwm_pkg::LANES; k++)
			n[k] = 0;
		if (cur_mode == mwm_pkg::MODE_TANK) begin
			n[0] = f * rpm;
			n[1] = s * rpm;
			n[2] = f * rpm;
			n[3] = s * rpm;
		end else if (cur_mode == mwm_pkg::MODE_ARCADE) begin
			n[0] = (f + t) * rpm;
			n[1] = (f - t) * rpm;
			n[2] = (f + t) * rpm;
			n[3] = (f - t) * rpm;
		end else if (cur_mode == mwm_pkg::MODE_XARC) begin
			m = ((f < 0) ? -f : f) + ((s < 0) ? -s : s);
			if (m == 0) begin
				// No translation: the turn term alone drives the wheels
				n[0] = t * rpm;
				n[1] = -t * rpm;
				n[2] = t * rpm;
				n[3] = -t * rpm;
			end else begin
				// hypot with 8 extra fraction bits, normalized by |f|+|s|
				h = longint'(int_root(longint'(f * f + s * s) << 16));
				tt = t * rpm * m * 256;
				pa = h * (f + s) * rpm;
				pb = h * (f - s) * rpm;
				d = m << 19;
				n[0] = pa + tt;
				n[1] = pb - tt;
				n[2] = pb + tt;
				n[3] = pa - tt;
			end
		end
		for (int k = 0; k < mwm_pkg::LANES; k++)
			r[k] = round_clamp(n[k], d);
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Output checker and watchdog
	// ---------------------------------------------------------------------

	always @(posedge clk) begin
		wheel_set_t got;
		wheel_set_t want;
		if (arst_n && out_valid && !out_stall) begin
			got[0] = front_left_speed;
			got[1] = front_right_speed;
			got[2] = rear_left_speed;
			got[3] = rear_right_speed;
			beats_out++;
			if (speeds_due.size() == 0) begin
				errors++;
				$display("%0t: wheel beat with nothing pending: %h", $time, got);
			end else begin
				want = speeds_due.pop_front();
				for (int k = 0; k < mwm_pkg::LANES; k++)
					if (got[k] !== want[k]) begin
						errors++;
						$display("%0t: %s_speed expected %0d actual %0d", $time,
							wheel_name[k], $signed(want[k]), $signed(got[k]));
					end
			end
		end
	end

	// Count cycles in which no beat moves on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d wheel beats pending",
				$time, STALL_LIMIT, speeds_due.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// Pace plan: receiver stalls most, then sender idles most, then full rate
	function automatic void set_pace(int stage);
		if (stage == 0) begin
			send_idle_pct = 34;
			recv_stall_pct = 55;
		end else if (stage == 1) begin
			send_idle_pct = 55;
			recv_stall_pct = 34;
		end else begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
	endfunction

	// Drive one axis beat; record the expected wheels when it is accepted
	task automatic send_axes(logic signed [mwm_pkg::AXIS_W-1:0] a1,
			logic signed [mwm_pkg::AXIS_W-1:0] a2, logic signed [mwm_pkg::AXIS_W-1:0] at,
			bit typed, wheel_set_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		first_axis <= a1;
		second_axis <= a2;
		turn_axis <= at;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		speeds_due.push_back(typed ? want : mix_wheels(a1, a2, at));
		beats_in++;
		mode_beats[cur_mode]++;
		@(negedge clk);
	endtask

	// Drop valid and let every pending wheel beat come back
	task automatic drain;
		in_valid <= 1'b0;
		while (speeds_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write all three registers back to back, plus an ignored index if asked
	task automatic write_regs(logic [mwm_pkg::CFG_DATA_W-1:0] mode_w,
			logic [mwm_pkg::CFG_DATA_W-1:0] dz_w, logic [mwm_pkg::CFG_DATA_W-1:0] rpm_w,
			bit add_unused);
		logic [mwm_pkg::CFG_IDX_W-1:0]  idx [4];
		logic [mwm_pkg::CFG_DATA_W-1:0] dat [4];
		int                             cnt;
		idx[0] = mwm_pkg::REG_DRIVE_MODE;
		dat[0] = mode_w;
		idx[1] = mwm_pkg::REG_DEADZONE;
		dat[1] = dz_w;
		idx[2] = mwm_pkg::REG_FULL_RPM;
		dat[2] = rpm_w;
		idx[3] = REG_UNUSED;
		dat[3] = 16'($urandom);
		cnt = add_unused ? 4 : 3;
		for (int i = 0; i < cnt; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= dat[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx[i])
				mwm_pkg::REG_DRIVE_MODE: cur_mode = dat[i][mwm_pkg::MODE_W-1:0];
				mwm_pkg::REG_DEADZONE:   cur_dz = dat[i][mwm_pkg::DZ_W-1:0];
				mwm_pkg::REG_FULL_RPM:   cur_rpm = dat[i][mwm_pkg::RPM_W-1:0];
				default:                 ;
			endcase
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Axis value biased toward extremes and the deadzone edge
	function automatic logic signed [mwm_pkg::AXIS_W-1:0] pick_axis();
		logic [mwm_pkg::AXIS_W-1:0] dz16;
		dz16 = {1'b0, cur_dz};
		case ($urandom_range(7))
			0: case ($urandom_range(4))
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				2: return 16'sh0000;
				3: return 16'sh0001;
				default: return 16'shFFFF;
			endcase
			1: case ($urandom_range(3))
				0: return dz16;
				1: return -dz16;
				2: return dz16 - 16'd1;
				default: return 16'd1 - dz16;
			endcase
			default: return 16'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------

	initial begin
		logic [mwm_pkg::CFG_DATA_W-1:0] last_mode;
		logic [mwm_pkg::CFG_DATA_W-1:0] last_dz;
		logic [mwm_pkg::CFG_DATA_W-1:0] last_rpm;
		logic [mwm_pkg::CFG_DATA_W-1:0] m_w;
		logic [mwm_pkg::CFG_DATA_W-1:0] dz_w;
		logic [mwm_pkg::CFG_DATA_W-1:0] rpm_w;
		wheel_set_t                     none;

		wheel_name = '{"front_left", "front_right", "rear_left", "rear_right"};
		none = '0;
		// mode, deadzone, rpm (raw write data), axes, typed flag, typed wheels
		dir_rows = '{
			'{16'(mwm_pkg::MODE_TANK), 16'd0, 16'd200, 16'sd0, 16'sd0, 16'sd0, 1'b1, '0},
			'{16'(mwm_pkg::MODE_TANK), 16'd0, 16'd200, 16'sh7FFF, 16'sh8000, 16'sd123,
				1'b1, {16'hF380, 16'd3200, 16'hF380, 16'd3200}},
			'{16'(mwm_pkg::MODE_TANK), 16'd0, 16'd1023, 16'sh7FFF, 16'sh8000, 16'sd0,
				1'b0, '0},
			'{16'(mwm_pkg::MODE_ARCADE), 16'd0, 16'd600, 16'sh7FFF, 16'sd0, 16'sh8000,
				1'b0, '0},
			'{16'(mwm_pkg::MODE_ARCADE), 16'd0, 16'd1023, 16'sh8000, 16'sd77, 16'sh8000,
				1'b0, '0},
			'{16'(mwm_pkg::MODE_ARCADE), 16'd0, 16'd1023, 16'sd1, -16'sd1, 16'sd1,
				1'b0, '0},
			'{16'(mwm_pkg::MODE_XARC), 16'd0, 16'd1023, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
				1'b0, '0},
			'{16'(mwm_pkg::MODE_XARC), 16'd0, 16'd1023, 16'sh8000, 16'sh8000, 16'sh8000,
				1'b0, '0},
			'{16'(mwm_pkg::MODE_XARC), 16'd0, 16'd600, 16'sd0, 16'sd0, 16'sh7FFF,
				1'b0, '0},
			'{16'(mwm_pkg::MODE_XARC), 16'd0, 16'd600, 16'sd20000, -16'sd5000, 16'sd0,
				1'b0, '0},
			'{16'(mwm_pkg::MODE_XARC), 16'd0, 16'd600, 16'sd0, 16'sh8000, 16'sd1000,
				1'b0, '0},
			'{16'(mwm_pkg::MODE_XARC), 16'd1000, 16'd600, 16'sd999, -16'sd999, 16'sd999,
				1'b1, '0},
			'{16'(mwm_pkg::MODE_XARC), 16'd1000, 16'd600, 16'sd1000, -16'sd1000,
				-16'sd1000, 1'b0, '0},
			'{16'(mwm_pkg::MODE_XARC), 16'd32767, 16'd600, 16'sh8000, 16'sh7FFF,
				-16'sd32767, 1'b0, '0},
			'{16'(MODE_UNUSED), 16'd0, 16'd600, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, '0},
			'{16'(mwm_pkg::MODE_TANK), 16'd0, 16'd0, 16'sh7FFF, 16'sh8000, 16'sd5,
				1'b1, '0},
			// Upper data bits above each register's width must be dropped
			'{16'hFFFD, 16'h8010, 16'hFE58, 16'sh4000, -16'sd17, 16'sh9000, 1'b0, '0}
		};

		// Hold every input at a known value from time zero
		arst_n = 1'b0;
		in_valid = 1'b0;
		first_axis = '0;
		second_axis = '0;
		turn_axis = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = mwm_pkg::REG_DRIVE_MODE;
		cfg_data = '0;
		errors = 0;
		beats_in = 0;
		beats_out = 0;
		idle_cycles = 0;
		mode_beats = '{0, 0, 0, 0};
		cur_mode = mwm_pkg::MODE_TANK;
		cur_dz = '0;
		cur_rpm = mwm_pkg::RPM_RESET;
		last_mode = 16'(mwm_pkg::MODE_TANK);
		last_dz = '0;
		last_rpm = 16'(mwm_pkg::RPM_RESET);
		set_pace(0);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows: the first ones run on the reset register values
		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode_w != last_mode || dir_rows[i].dz_w != last_dz ||
					dir_rows[i].rpm_w != last_rpm) begin
				drain();
				write_regs(dir_rows[i].mode_w, dir_rows[i].dz_w, dir_rows[i].rpm_w, 1'b0);
				last_mode = dir_rows[i].mode_w;
				last_dz = dir_rows[i].dz_w;
				last_rpm = dir_rows[i].rpm_w;
			end
			send_axes(dir_rows[i].a1, dir_rows[i].a2, dir_rows[i].at,
				dir_rows[i].typed, dir_rows[i].typed ? dir_rows[i].want : none);
		end

		// Random segments, each with its own register setting and pace
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			set_pace(seg * 3 / SEGMENTS);
			m_w = 16'($urandom);
			if ($urandom_range(9) != 0)
				m_w[mwm_pkg::MODE_W-1:0] = 2'($urandom_range(2));
			case ($urandom_range(4))
				0: dz_w = 16'd0;
				1: dz_w = 16'h7FFF | 16'($urandom_range(1) << 15);
				2: dz_w = 16'($urandom);
				default: dz_w = 16'($urandom_range(4000));
			endcase
			case ($urandom_range(4))
				0: rpm_w = 16'd0;
				1: rpm_w = 16'd600;
				2: rpm_w = 16'd1023;
				default: rpm_w = 16'($urandom);
			endcase
			drain();
			write_regs(m_w, dz_w, rpm_w, seg == 0);
			for (int i = 0; i < SEG_ITEMS; i++)
				send_axes(pick_axis(), pick_axis(), pick_axis(), 1'b0, none);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d axis beats (tank %0d, arcade %0d, x-arcade %0d, unused mode %0d),",
			beats_in, mode_beats[0], mode_beats[1], mode_beats[2], mode_beats[3]);
		$display("checked %0d wheel beats, %0d directed rows and %0d random settings, %0d mismatches.",
			beats_out, DIR_ROWS, SEGMENTS, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
